FILE: hw/rtl/lerb_pkg.sv
package lerb_pkg;

   localparam int BUFFER_DEPTH = 256;
   localparam int IDX_W = $clog2(BUFFER_DEPTH);
   localparam int CNT_W = $clog2(BUFFER_DEPTH);

   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_DEL = 8'h7F;
   localparam logic [7:0] CH_BEL = 8'h07;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;

   typedef enum logic [1:0] {
      KIND_STATUS = 2'd0,
      KIND_TX     = 2'd1,
      KIND_TAKEN  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] rx_byte;
      logic       tx_idle;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
      logic       line_ready;
      logic       is_empty;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic mem_read;
      logic exec;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic final_result;
   } status_type;

   function automatic logic is_terminator(input logic [7:0] c);
      return (c == CH_CR) || (c == CH_LF);
   endfunction

   function automatic logic is_erase(input logic [7:0] c);
      return (c == CH_BS) || (c == CH_DEL);
   endfunction

   function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(BUFFER_DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
      return (i == '0) ? IDX_W'(BUFFER_DEPTH - 1) : i - 1'b1;
   endfunction

endpackage

FILE: hw/rtl/lerb_control.sv
module lerb_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  lerb_pkg::status_type status,
   output lerb_pkg::cmd_type    cmd
);
   import lerb_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_READ;
         end
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: state_in = ST_SEND;
         ST_SEND: begin
            if (!rsp_stall && status.final_result) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_READ: cmd.mem_read = 1'b1;
         ST_EXEC: cmd.exec = 1'b1;
         ST_SEND: begin
            rsp_valid   = 1'b1;
            cmd.advance = !rsp_stall;
         end
         default: req_stall = 1'b1;
      endcase
   end

endmodule

FILE: hw/rtl/lerb_datapath.sv
module lerb_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  lerb_pkg::cmd_type    cmd,
   input  lerb_pkg::req_type    req_item,
   output lerb_pkg::status_type status,
   output lerb_pkg::rsp_type    rsp_item
);
   import lerb_pkg::*;

   logic [7:0] mem [BUFFER_DEPTH];

   req_type          req_ff;
   logic [7:0]       rd_data_ff;
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] term_cnt_ff, term_cnt_in;
   kind_type         kind_ff, kind_in;
   logic [7:0]       data_ff, data_in;
   logic             triple_ff, triple_in;
   logic [1:0]       seq_ff;
   logic             mem_we;
   logic [IDX_W-1:0] rd_addr;
   logic             empty;
   logic             full;
   logic             final_result;

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_item;
   end

   assign rd_addr = req_ff.mode ? rd_idx_ff : idx_prev(wr_idx_ff);

   always_ff @(posedge clock) begin
      if (cmd.mem_read) rd_data_ff <= mem[rd_addr];
      if (mem_we) mem[wr_idx_ff] <= req_ff.rx_byte;
   end

   assign empty = (wr_idx_ff == rd_idx_ff);
   assign full  = (idx_next(wr_idx_ff) == rd_idx_ff);

   always_comb begin
      wr_idx_in   = wr_idx_ff;
      rd_idx_in   = rd_idx_ff;
      term_cnt_in = term_cnt_ff;
      kind_in     = KIND_STATUS;
      data_in     = 8'h00;
      triple_in   = 1'b0;
      mem_we      = 1'b0;
      if (cmd.exec) begin
         if (req_ff.mode) begin
            if (!empty) begin
               kind_in   = KIND_TAKEN;
               data_in   = rd_data_ff;
               rd_idx_in = idx_next(rd_idx_ff);
               if (is_terminator(rd_data_ff) && term_cnt_ff != '0) begin
                  term_cnt_in = term_cnt_ff - 1'b1;
               end
            end
         end else if (is_erase(req_ff.rx_byte)) begin
            if (!empty) begin
               wr_idx_in = idx_prev(wr_idx_ff);
               triple_in = req_ff.tx_idle;
               if (is_terminator(rd_data_ff) && term_cnt_ff != '0) begin
                  term_cnt_in = term_cnt_ff - 1'b1;
               end
            end else if (req_ff.tx_idle) begin
               kind_in = KIND_TX;
               data_in = CH_BEL;
            end
         end else begin
            if (!full) begin
               mem_we    = 1'b1;
               wr_idx_in = idx_next(wr_idx_ff);
               if (is_terminator(req_ff.rx_byte)) term_cnt_in = term_cnt_ff + 1'b1;
               if (req_ff.tx_idle) begin
                  kind_in = KIND_TX;
                  data_in = req_ff.rx_byte;
               end
            end else if (req_ff.tx_idle) begin
               kind_in = KIND_TX;
               data_in = CH_BEL;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff   <= '0;
         rd_idx_ff   <= '0;
         term_cnt_ff <= '0;
      end else begin
         wr_idx_ff   <= wr_idx_in;
         rd_idx_ff   <= rd_idx_in;
         term_cnt_ff <= term_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         kind_ff   <= kind_in;
         data_ff   <= data_in;
         triple_ff <= triple_in;
      end
   end

   assign final_result = !triple_ff || (seq_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= 2'd0;
      end else if (cmd.exec) begin
         seq_ff <= 2'd0;
      end else if (cmd.advance) begin
         seq_ff <= final_result ? 2'd0 : seq_ff + 2'd1;
      end
   end

   assign status.final_result = final_result;

   always_comb begin
      rsp_item.kind       = triple_ff ? KIND_TX : kind_ff;
      rsp_item.data       = triple_ff ? ((seq_ff == 2'd1) ? CH_SP : CH_BS) : data_ff;
      rsp_item.last       = final_result;
      rsp_item.line_ready = (term_cnt_ff != '0);
      rsp_item.is_empty   = empty;
   end

endmodule

FILE: hw/rtl/line_edit_receive_ring_buffer.sv
// Receive-side line buffer with backspace editing.
// Requests enter on the req_ channel: mode 0 hands over a byte received from
// the line, mode 1 takes the oldest buffered byte. Each request yields one
// or three results on the rsp_ channel, the final one flagged by last, and
// every result reports line_ready and is_empty for the state after the request.
// A request is taken only while the block is idle. It then passes through the
// READ state, which registers the buffer memory read, and the EXEC state, which
// makes the update; the results follow in the SEND state, one result per cycle
// while the receiver does not stall, and a new request is taken only after the
// final result has been sent.
// When the receiver stalls, the current result holds and the next request
// waits. Reset clears the indices and the terminator count, so the buffer
// starts empty at once; the memory contents need no clearing.
module line_edit_receive_ring_buffer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lerb_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lerb_pkg::rsp_type rsp_item
);
   import lerb_pkg::*;

   cmd_type    cmd;
   status_type status;

   lerb_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lerb_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_item (req_item),
      .status   (status),
      .rsp_item (rsp_item)
   );

endmodule
